// File: hdl/ecbm_pkg.sv
// ----------------------------------------------------------------------------
// ecbm_pkg
// Shared types, constants and sizing for the endian checked byte memory.
// ----------------------------------------------------------------------------
package ecbm_pkg;

  // Store size in bytes; the store is kept as 64-bit words of eight byte lanes
  localparam longint unsigned MEM_BYTES = 64'd65536;
  localparam int WORDS   = int'((MEM_BYTES + 64'd7) / 64'd8);
  localparam int WORD_AW = (WORDS > 1) ? $clog2(WORDS) : 1;

  localparam logic [64:0] MEM_LIMIT = 65'(MEM_BYTES);

  // Operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_BOUNDS = 2'd1;
  localparam logic [1:0] ST_ALIGN  = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [1:0]  access_size;
    logic [63:0] address;
    logic [63:0] write_data;
  } req_t;

  typedef struct packed {
    logic [63:0] read_data;
    logic [1:0]  status;
  } rsp_t;

  // Per-transaction information carried alongside the memory read
  typedef struct packed {
    logic       rd_ok;
    logic [2:0] offset;
    logic [1:0] size;
    logic       big_endian;
    logic [1:0] status;
  } meta_t;

  // Decoded memory command for one transaction
  typedef struct packed {
    logic               rd_en;
    logic [WORD_AW-1:0] word_addr;
    logic [7:0]         we;
    logic [63:0]        wdata;
    meta_t              meta;
  } cmd_t;

  // Value position of the byte at access index idx of an access of 2^size bytes
  function automatic logic [2:0] value_pos(input logic [2:0] idx, input logic [1:0] size,
                                           input logic big_endian);
    logic [2:0] last;
    last = 3'((4'd1 << size) - 4'd1);
    return big_endian ? 3'(last - idx) : idx;
  endfunction

endpackage

// File: hdl/ecbm_ram.sv
// ----------------------------------------------------------------------------
// ecbm_ram
// Single-port synchronous RAM with byte write enables and registered read.
// ----------------------------------------------------------------------------
module ecbm_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int LANES = 8
) (
  input  logic                 clk,
  input  logic [AW-1:0]        addr,
  input  logic                 re,
  input  logic [LANES-1:0]     we,
  input  logic [8*LANES-1:0]   wdata,
  output logic [8*LANES-1:0]   rdata
);

  logic [8*LANES-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
    for (int k = 0; k < LANES; k++) begin
      if (we[k]) begin
        mem[addr][8*k +: 8] <= wdata[8*k +: 8];
      end
    end
  end

endmodule

// File: hdl/ecbm_check.sv
// ----------------------------------------------------------------------------
// ecbm_check
// Bounds and alignment check, and byte-lane steering of write data.
// ----------------------------------------------------------------------------
module ecbm_check
  import ecbm_pkg::*;
(
  input  req_t req,
  input  logic big_endian,
  output cmd_t cmd
);

  logic [3:0]  nbytes;
  logic [64:0] end_addr;
  logic [2:0]  mask;
  logic [1:0]  status;
  logic [2:0]  offset;
  logic [2:0]  idx;
  logic [2:0]  pos;
  logic        ok;

  assign nbytes   = 4'd1 << req.access_size;
  assign end_addr = {1'b0, req.address} + 65'(nbytes);
  assign mask     = 3'(nbytes - 4'd1);
  assign offset   = req.address[2:0];

  // Bounds first (a 65-bit sum also catches a wrap past 2^64), then alignment
  always_comb begin
    priority if (end_addr > MEM_LIMIT) begin
      status = ST_BOUNDS;
    end else if ((offset & mask) != 3'd0) begin
      status = ST_ALIGN;
    end else begin
      status = ST_OK;
    end
  end

  assign ok = (status == ST_OK);

  always_comb begin
    cmd.we    = '0;
    cmd.wdata = '0;
    idx       = '0;
    pos       = '0;
    for (int k = 0; k < 8; k++) begin
      idx = 3'(k) - offset;
      pos = value_pos(idx, req.access_size, big_endian);
      if ({1'b0, idx} < nbytes) begin
        cmd.we[k] = ok && (req.operation == OP_WRITE);
        cmd.wdata[8*k +: 8] = req.write_data[8*pos +: 8];
      end
    end
    cmd.rd_en           = ok && (req.operation == OP_READ);
    cmd.word_addr       = req.address[WORD_AW+2:3];
    cmd.meta.rd_ok      = ok && (req.operation == OP_READ);
    cmd.meta.offset     = offset;
    cmd.meta.size       = req.access_size;
    cmd.meta.big_endian = big_endian;
    cmd.meta.status     = status;
  end

endmodule

// File: hdl/ecbm_format.sv
// ----------------------------------------------------------------------------
// ecbm_format
// Gathers the bytes of a read from the fetched word into value order.
// ----------------------------------------------------------------------------
module ecbm_format
  import ecbm_pkg::*;
(
  input  meta_t       meta,
  input  logic [63:0] word,
  output rsp_t        rsp
);

  logic [3:0] nbytes;
  logic [2:0] lane;

  assign nbytes = 4'd1 << meta.size;

  always_comb begin
    rsp.read_data = '0;
    lane          = '0;
    for (int p = 0; p < 8; p++) begin
      // value_pos is its own inverse, so it maps value position back to index
      lane = meta.offset + value_pos(3'(p), meta.size, meta.big_endian);
      if (meta.rd_ok && (4'(p) < nbytes)) begin
        rsp.read_data[8*p +: 8] = word[8*lane +: 8];
      end
    end
    rsp.status = meta.status;
  end

endmodule

// File: hdl/endian_checked_byte_memory.sv
// ----------------------------------------------------------------------------
// endian_checked_byte_memory
// Byte-addressed memory with bounds, alignment and byte order handling.
// ----------------------------------------------------------------------------
// The block accepts one transaction per clock cycle unless the response
// side stalls. The 64-bit wide single-port store is read at the accepting
// edge; the word and meta wait in the read stage until the response
// register is free; it then loads and raises rsp_valid. That single
// port, doing either one read or one byte-enabled write per cycle, sets
// the rate; every good access is aligned and so lies within one word. After
// reset all WORDS = MEM_BYTES/8 words (8192 at 64 KiB) are swept to zero one
// word a cycle with req_ready low; configuration writes are taken at all times.
module endian_checked_byte_memory
  import ecbm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  logic               big_endian;
  logic               clr_busy;
  logic [WORD_AW-1:0] clr_addr;
  logic               s1_valid;
  meta_t              s1_meta;
  logic               s1_adv;
  logic               req_acc;
  cmd_t               cmd;
  rsp_t               fmt_rsp;
  logic [WORD_AW-1:0] ram_addr;
  logic               ram_re;
  logic [7:0]         ram_we;
  logic [63:0]        ram_wdata;
  logic [63:0]        ram_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      big_endian <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      big_endian <= cfg_data;
    end
  end

  // Clearing sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == WORD_AW'(WORDS - 1)) begin
        clr_busy <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  assign s1_adv    = s1_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !clr_busy && (!s1_valid || s1_adv);
  assign req_acc   = req_valid && req_ready;

  ecbm_check u_check (
    .req        (req),
    .big_endian (big_endian),
    .cmd        (cmd)
  );

  assign ram_addr  = clr_busy ? clr_addr : cmd.word_addr;
  assign ram_re    = req_acc && cmd.rd_en;
  assign ram_we    = clr_busy ? 8'hFF : (req_acc ? cmd.we : 8'h00);
  assign ram_wdata = clr_busy ? 64'd0 : cmd.wdata;

  ecbm_ram #(
    .DEPTH (WORDS),
    .AW    (WORD_AW),
    .LANES (8)
  ) u_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .re    (ram_re),
    .we    (ram_we),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // Read stage: hold meta and RAM output until the response register frees up
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_acc) begin
      s1_meta <= cmd.meta;
    end
  end

  ecbm_format u_format (
    .meta (s1_meta),
    .word (ram_rdata),
    .rsp  (fmt_rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= fmt_rsp;
    end
  end

  a_no_req_during_clear: assert property (@(posedge clk) disable iff (rst)
    clr_busy |-> !req_ready)
    else $error("request accepted during clearing sweep");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    !(ram_re && (ram_we != 8'h00)))
    else $error("memory read and write issued together");

  a_err_zero_data: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp.status != ST_OK)) |-> (rsp.read_data == 64'd0))
    else $error("rejected access returned data");

  a_write_lanes: assert property (@(posedge clk) disable iff (rst)
    (req_acc && (cmd.meta.status == ST_OK) && (req.operation == OP_WRITE))
      |-> ($countones(ram_we) == (32'd1 << req.access_size)))
    else $error("write byte enables do not match access size");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_meta)))
    else $error("read stage dropped a transaction");

endmodule
